[hdl/sti_pkg.sv]
package sti_pkg;

    typedef logic signed [15:0] t_word;
    typedef logic [1:0]         t_alu_op;

    localparam t_alu_op ALU_ADD = 2'd0;
    localparam t_alu_op ALU_SUB = 2'd1;
    localparam t_alu_op ALU_ABS = 2'd2;
    localparam t_alu_op ALU_MUL = 2'd3;

    typedef struct packed {
        t_alu_op op;
        t_word   a;
        t_word   b;
    } t_alu_req;

    typedef struct packed {
        t_word res;
        logic  neg;
    } t_alu_rsp;

    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_CONVERT = 1'b1;
    localparam logic KIND_SHORT  = 1'b0;
    localparam logic KIND_LONG   = 1'b1;

    localparam logic [2:0] REG_SHORT_MAX  = 3'd0;
    localparam logic [2:0] REG_SHORT_MIN  = 3'd1;
    localparam logic [2:0] REG_LONG_MAX   = 3'd2;
    localparam logic [2:0] REG_LONG_MIN   = 3'd3;
    localparam logic [2:0] REG_SHORT_LAST = 3'd4;
    localparam logic [2:0] REG_LONG_LAST  = 3'd5;
    localparam logic [2:0] REG_SHORT_STEP = 3'd6;
    localparam logic [2:0] REG_LONG_STEP  = 3'd7;

    localparam logic [7:0] NEAR_SHORT_CM = 8'd4;
    localparam logic [7:0] FAR_SHORT_CM  = 8'd30;
    localparam logic [7:0] NEAR_LONG_CM  = 8'd10;
    localparam logic [7:0] FAR_LONG_CM   = 8'd70;

    localparam int DIV_STEPS = 14;

endpackage

[hdl/sensor_table_interpolator.sv]
// Write word: written into the table of its sensor kind, no result.
// Convert word, clamped: the sequencer goes to S_DONE, which loads the result register.
// Convert word, interpolated: binary search with probes on the registered table read,
//   five setup steps, 14 divide steps, then sum and load.
// One word in flight; ready only while the sequencer idles. The result register frees it.
// Synchronous active-low reset clears the sequencer and output valid and loads config defaults.
module sensor_table_interpolator #(
    parameter int SHORT_TABLE_DEPTH = 16,
    parameter int LONG_TABLE_DEPTH  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // entry_index[3:0], entry_value[13:4], sample[23:14]
    input  logic [1:0]  s_axis_tuser,  // req_type[0], sensor_kind[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // distance_cm[7:0]
    output logic        m_axis_tuser,  // clamped[0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SEARCH = 4'd1;
    localparam logic [3:0] S_PROBE  = 4'd2;
    localparam logic [3:0] S_RD_HI  = 4'd3;
    localparam logic [3:0] S_RD_LO  = 4'd4;
    localparam logic [3:0] S_DIFF   = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_BASE   = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_SUM    = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [9:0] r_short_max, r_short_min, r_long_max, r_long_min;
    logic [3:0] r_short_last, r_long_last, r_short_step, r_long_step;

    logic [3:0]          r_state, n_state;
    logic                r_kind, n_kind;
    logic [9:0]          r_sample, n_sample;
    logic [3:0]          r_last, n_last;
    logic [3:0]          r_step, n_step;
    logic [3:0]          r_lower, n_lower;
    logic [3:0]          r_span, n_span;
    logic [9:0]          r_hi, n_hi;
    logic [9:0]          r_den_abs, n_den_abs;
    logic                r_den_neg, n_den_neg;
    logic                r_den_zero, n_den_zero;
    logic                r_neg, n_neg;
    logic [13:0]         r_num, n_num;
    logic [9:0]          r_rem, n_rem;
    logic [7:0]          r_base, n_base;
    logic [3:0]          r_cnt, n_cnt;
    sti_pkg::t_word      r_acc, n_acc;
    logic                r_clamped, n_clamped;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_out_data, n_out_data;
    logic                r_out_user, n_out_user;

    logic                w_in_req, w_in_kind;
    logic [3:0]          w_in_idx;
    logic [9:0]          w_in_val, w_in_sample;
    logic                w_accept;
    logic [9:0]          w_max, w_min;
    logic [3:0]          w_last_in, w_step_in;
    logic [3:0]          w_span_half;
    logic [4:0]          w_probe;
    logic [3:0]          w_last_m1;
    logic [3:0]          w_lower_lim;
    logic [3:0]          w_rd_idx;
    logic [9:0]          w_short_rd, w_long_rd, w_rd_data;
    logic [10:0]         w_rem_shift;
    sti_pkg::t_alu_req   w_alu_req;
    sti_pkg::t_alu_rsp   w_alu_rsp;

    assign w_in_req    = s_axis_tuser[0];
    assign w_in_kind   = s_axis_tuser[1];
    assign w_in_idx    = s_axis_tdata[3:0];
    assign w_in_val    = s_axis_tdata[13:4];
    assign w_in_sample = s_axis_tdata[23:14];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_max  <= 10'd1023;
            r_short_min  <= 10'd0;
            r_long_max   <= 10'd1023;
            r_long_min   <= 10'd0;
            r_short_last <= 4'd15;
            r_long_last  <= 4'd15;
            r_short_step <= 4'd1;
            r_long_step  <= 4'd5;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                sti_pkg::REG_SHORT_MAX:  r_short_max  <= i_cfg_data;
                sti_pkg::REG_SHORT_MIN:  r_short_min  <= i_cfg_data;
                sti_pkg::REG_LONG_MAX:   r_long_max   <= i_cfg_data;
                sti_pkg::REG_LONG_MIN:   r_long_min   <= i_cfg_data;
                sti_pkg::REG_SHORT_LAST: r_short_last <= i_cfg_data[3:0];
                sti_pkg::REG_LONG_LAST:  r_long_last  <= i_cfg_data[3:0];
                sti_pkg::REG_SHORT_STEP: r_short_step <= i_cfg_data[3:0];
                sti_pkg::REG_LONG_STEP:  r_long_step  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign w_max     = (w_in_kind == sti_pkg::KIND_LONG) ? r_long_max  : r_short_max;
    assign w_min     = (w_in_kind == sti_pkg::KIND_LONG) ? r_long_min  : r_short_min;
    assign w_last_in = (w_in_kind == sti_pkg::KIND_LONG) ? r_long_last : r_short_last;
    assign w_step_in = (w_in_kind == sti_pkg::KIND_LONG) ? r_long_step : r_short_step;

    assign w_span_half = 4'((5'(r_span) + 5'(r_span[0])) >> 1);
    assign w_probe     = 5'(r_lower) + 5'(w_span_half);
    assign w_last_m1   = r_last - 4'd1;
    assign w_lower_lim = (r_lower > w_last_m1) ? w_last_m1 : r_lower;
    assign w_rem_shift = {r_rem, r_num[13]};

    sti_table #(
        .DEPTH(SHORT_TABLE_DEPTH)
    ) u_short_table (
        .i_clk    (i_clk),
        .i_wr_en  (w_accept && w_in_req == sti_pkg::REQ_WRITE
                   && w_in_kind == sti_pkg::KIND_SHORT),
        .i_wr_idx (w_in_idx),
        .i_wr_data(w_in_val),
        .i_rd_idx (w_rd_idx),
        .o_rd_data(w_short_rd)
    );

    sti_table #(
        .DEPTH(LONG_TABLE_DEPTH)
    ) u_long_table (
        .i_clk    (i_clk),
        .i_wr_en  (w_accept && w_in_req == sti_pkg::REQ_WRITE
                   && w_in_kind == sti_pkg::KIND_LONG),
        .i_wr_idx (w_in_idx),
        .i_wr_data(w_in_val),
        .i_rd_idx (w_rd_idx),
        .o_rd_data(w_long_rd)
    );

    assign w_rd_data = (r_kind == sti_pkg::KIND_LONG) ? w_long_rd : w_short_rd;

    sti_alu u_alu (
        .i_req(w_alu_req),
        .o_rsp(w_alu_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_sample    = r_sample;
        n_last      = r_last;
        n_step      = r_step;
        n_lower     = r_lower;
        n_span      = r_span;
        n_hi        = r_hi;
        n_den_abs   = r_den_abs;
        n_den_neg   = r_den_neg;
        n_den_zero  = r_den_zero;
        n_neg       = r_neg;
        n_num       = r_num;
        n_rem       = r_rem;
        n_base      = r_base;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_clamped   = r_clamped;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_valid = r_out_valid && !m_axis_tready;
        w_rd_idx    = r_lower;
        w_alu_req   = '{op: sti_pkg::ALU_ADD, a: '0, b: '0};

        case (r_state)
            S_IDLE: begin
                if (w_accept && w_in_req == sti_pkg::REQ_CONVERT) begin
                    n_kind   = w_in_kind;
                    n_sample = w_in_sample;
                    n_last   = (w_last_in == 4'd0) ? 4'd1 : w_last_in;
                    n_span   = (w_last_in == 4'd0) ? 4'd1 : w_last_in;
                    n_step   = w_step_in;
                    n_lower  = 4'd0;
                    if (w_in_sample > w_max) begin
                        n_acc     = sti_pkg::t_word'((w_in_kind == sti_pkg::KIND_LONG) ?
                                    sti_pkg::NEAR_LONG_CM : sti_pkg::NEAR_SHORT_CM);
                        n_clamped = 1'b1;
                        n_state   = S_DONE;
                    end else if (w_in_sample < w_min) begin
                        n_acc     = sti_pkg::t_word'((w_in_kind == sti_pkg::KIND_LONG) ?
                                    sti_pkg::FAR_LONG_CM : sti_pkg::FAR_SHORT_CM);
                        n_clamped = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        n_clamped = 1'b0;
                        n_state   = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (r_span > 4'd1) begin
                    n_span = w_span_half;
                    if (w_probe <= {1'b0, r_last}) begin
                        w_rd_idx = w_probe[3:0];
                        n_state  = S_PROBE;
                    end
                end else begin
                    n_lower  = w_lower_lim;
                    w_rd_idx = w_lower_lim;
                    n_state  = S_RD_HI;
                end
            end
            S_PROBE: begin
                w_alu_req = '{op: sti_pkg::ALU_SUB, a: sti_pkg::t_word'(w_rd_data),
                              b: sti_pkg::t_word'(r_sample)};
                if (!w_alu_rsp.neg) begin
                    n_lower = r_lower + r_span;
                end
                n_state = S_SEARCH;
            end
            S_RD_HI: begin
                n_hi     = w_rd_data;
                w_rd_idx = r_lower + 4'd1;
                n_state  = S_RD_LO;
            end
            S_RD_LO: begin
                w_alu_req  = '{op: sti_pkg::ALU_ABS, a: sti_pkg::t_word'(r_hi),
                               b: sti_pkg::t_word'(w_rd_data)};
                n_den_abs  = w_alu_rsp.res[9:0];
                n_den_neg  = w_alu_rsp.neg;
                n_den_zero = (w_alu_rsp.res == '0);
                n_state    = S_DIFF;
            end
            S_DIFF: begin
                w_alu_req = '{op: sti_pkg::ALU_ABS, a: sti_pkg::t_word'(r_hi),
                              b: sti_pkg::t_word'(r_sample)};
                n_num     = w_alu_rsp.res[13:0];
                n_neg     = w_alu_rsp.neg ^ r_den_neg;
                n_state   = S_MUL;
            end
            S_MUL: begin
                w_alu_req = '{op: sti_pkg::ALU_MUL, a: sti_pkg::t_word'(r_num),
                              b: sti_pkg::t_word'(r_step)};
                n_num     = w_alu_rsp.res[13:0];
                n_state   = S_BASE;
            end
            S_BASE: begin
                w_alu_req = '{op: sti_pkg::ALU_MUL,
                              a: sti_pkg::t_word'(5'(r_lower) + 5'd2),
                              b: sti_pkg::t_word'(r_step)};
                n_base    = w_alu_rsp.res[7:0];
                n_rem     = 10'd0;
                n_cnt     = 4'd0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                w_alu_req = '{op: sti_pkg::ALU_SUB, a: sti_pkg::t_word'(w_rem_shift),
                              b: sti_pkg::t_word'(r_den_abs)};
                n_rem     = w_alu_rsp.neg ? w_rem_shift[9:0] : w_alu_rsp.res[9:0];
                n_num     = {r_num[12:0], !w_alu_rsp.neg};
                n_cnt     = r_cnt + 4'd1;
                if (r_cnt == 4'(sti_pkg::DIV_STEPS - 1)) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                w_alu_req = '{op: r_neg ? sti_pkg::ALU_SUB : sti_pkg::ALU_ADD,
                              a: sti_pkg::t_word'(r_base),
                              b: r_den_zero ? sti_pkg::t_word'(0) : sti_pkg::t_word'(r_num)};
                n_acc     = w_alu_rsp.res;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_user  = r_clamped;
                    if (r_acc < 0) begin
                        n_out_data = 8'd0;
                    end else if (r_acc > 16'sd255) begin
                        n_out_data = 8'd255;
                    end else begin
                        n_out_data = r_acc[7:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_sample   <= n_sample;
        r_last     <= n_last;
        r_step     <= n_step;
        r_lower    <= n_lower;
        r_span     <= n_span;
        r_hi       <= n_hi;
        r_den_abs  <= n_den_abs;
        r_den_neg  <= n_den_neg;
        r_den_zero <= n_den_zero;
        r_neg      <= n_neg;
        r_num      <= n_num;
        r_rem      <= n_rem;
        r_base     <= n_base;
        r_cnt      <= n_cnt;
        r_acc      <= n_acc;
        r_clamped  <= n_clamped;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

`ifndef SYNTH
    a_probe_follows_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PROBE |-> $past(r_state) == S_SEARCH)
        else $error("probe without search step");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PROBE |-> $past(w_rd_idx) <= r_last)
        else $error("probe beyond last used entry");

    a_segment_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RD_LO |-> r_lower < r_last)
        else $error("segment past last entry");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !r_den_zero) |-> r_rem < r_den_abs)
        else $error("divide remainder not below divisor");
`endif

endmodule

[hdl/sti_alu.sv]
module sti_alu (
    input  sti_pkg::t_alu_req i_req,
    output sti_pkg::t_alu_rsp o_rsp
);

    logic signed [16:0] w_sum;
    logic signed [16:0] w_diff;
    logic        [19:0] w_prod;

    assign w_sum  = 17'(i_req.a) + 17'(i_req.b);
    assign w_diff = 17'(i_req.a) - 17'(i_req.b);
    assign w_prod = 20'(unsigned'(i_req.a)) * 20'(i_req.b[3:0]);

    always_comb begin
        case (i_req.op)
            sti_pkg::ALU_ADD: begin
                o_rsp.res = 16'(w_sum);
                o_rsp.neg = w_sum[16];
            end
            sti_pkg::ALU_SUB: begin
                o_rsp.res = 16'(w_diff);
                o_rsp.neg = w_diff[16];
            end
            sti_pkg::ALU_ABS: begin
                o_rsp.res = w_diff[16] ? 16'(-w_diff) : 16'(w_diff);
                o_rsp.neg = w_diff[16];
            end
            sti_pkg::ALU_MUL: begin
                o_rsp.res = 16'(w_prod);
                o_rsp.neg = 1'b0;
            end
            default: begin
                o_rsp.res = '0;
                o_rsp.neg = 1'b0;
            end
        endcase
    end

endmodule

[hdl/sti_table.sv]
module sti_table #(
    parameter int DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_wr_en,
    input  logic [3:0] i_wr_idx,
    input  logic [9:0] i_wr_data,
    input  logic [3:0] i_rd_idx,
    output logic [9:0] o_rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [9:0] mem [DEPTH];
    logic [9:0] r_rd_data;
    logic       w_wr_ok;
    logic       w_rd_ok;

    assign w_wr_ok = 32'(i_wr_idx) < DEPTH;
    assign w_rd_ok = 32'(i_rd_idx) < DEPTH;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && w_wr_ok) begin
            mem[AW'(i_wr_idx)] <= i_wr_data;
        end
    end

    // out-of-range entries read as zero
    always_ff @(posedge i_clk) begin
        r_rd_data <= w_rd_ok ? mem[AW'(i_rd_idx)] : 10'd0;
    end

    assign o_rd_data = r_rd_data;

endmodule

[sim/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHORT_DEPTH   = 16;
    localparam int LONG_DEPTH    = 16;
    localparam int HALF_PERIOD   = 5;
    localparam int GAP_MAX       = 12;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 30;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int REG_COUNT     = 8;

    typedef struct packed {
        logic       req_type;
        logic       sensor_kind;
        logic [3:0] entry_index;
        logic [9:0] entry_value;
        logic [9:0] sample;
    } t_sensor_word;

    typedef struct packed {
        logic       clamped;
        logic [7:0] distance_cm;
    } t_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [9:0]  i_cfg_data = '0;

    logic [9:0] short_tab [SHORT_DEPTH];
    logic [9:0] long_tab [LONG_DEPTH];
    logic [9:0] cfg_regs [REG_COUNT];
    logic [9:0] next_cfg [REG_COUNT];
    t_reading   expected_readings [$];
    int         errors = 0;
    bit         steady = 1'b0;

    sensor_table_interpolator #(
        .SHORT_TABLE_DEPTH(SHORT_DEPTH),
        .LONG_TABLE_DEPTH (LONG_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int pick_gap();
        if (steady || $urandom_range(0, 3) == 0)
            return 0;
        return int'($urandom_range(0, GAP_MAX));
    endfunction

    function automatic int table_entry(logic kind, int idx);
        if (kind == sti_pkg::KIND_LONG)
            return (idx < LONG_DEPTH) ? int'(long_tab[idx]) : 0;
        return (idx < SHORT_DEPTH) ? int'(short_tab[idx]) : 0;
    endfunction

    function automatic t_reading predict_reading(logic kind, logic [9:0] smp);
        int s, maxv, minv, last, step, lower, span, hi, lo, num, den, frac, total;
        t_reading r;
        s = int'(smp);
        if (kind == sti_pkg::KIND_LONG) begin
            maxv = int'(cfg_regs[sti_pkg::REG_LONG_MAX]);
            minv = int'(cfg_regs[sti_pkg::REG_LONG_MIN]);
            last = int'(cfg_regs[sti_pkg::REG_LONG_LAST][3:0]);
            step = int'(cfg_regs[sti_pkg::REG_LONG_STEP][3:0]);
        end else begin
            maxv = int'(cfg_regs[sti_pkg::REG_SHORT_MAX]);
            minv = int'(cfg_regs[sti_pkg::REG_SHORT_MIN]);
            last = int'(cfg_regs[sti_pkg::REG_SHORT_LAST][3:0]);
            step = int'(cfg_regs[sti_pkg::REG_SHORT_STEP][3:0]);
        end
        r.clamped = 1'b1;
        if (s > maxv) begin
            r.distance_cm = (kind == sti_pkg::KIND_LONG) ?
                            sti_pkg::NEAR_LONG_CM : sti_pkg::NEAR_SHORT_CM;
        end else if (s < minv) begin
            r.distance_cm = (kind == sti_pkg::KIND_LONG) ?
                            sti_pkg::FAR_LONG_CM : sti_pkg::FAR_SHORT_CM;
        end else begin
            r.clamped = 1'b0;
            if (last == 0)
                last = 1;
            lower = 0;
            span  = last;
            while (span > 1) begin
                if (span % 2 == 1)
                    span++;
                span = span / 2;
                if (lower + span <= last && s <= table_entry(kind, lower + span))
                    lower += span;
            end
            if (lower > last - 1)
                lower = last - 1;
            hi    = table_entry(kind, lower);
            lo    = table_entry(kind, lower + 1);
            num   = step * (hi - s);
            den   = hi - lo;
            frac  = (den == 0) ? 0 : num / den;
            total = (lower + 2) * step + frac;
            if (total < 0)
                total = 0;
            if (total > 255)
                total = 255;
            r.distance_cm = total[7:0];
        end
        return r;
    endfunction

    task automatic send_word(input t_sensor_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {w.sample, w.entry_value, w.entry_index};
        s_axis_tuser  <= {w.sensor_kind, w.req_type};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (w.req_type == sti_pkg::REQ_WRITE) begin
            if (w.sensor_kind == sti_pkg::KIND_LONG)
                long_tab[w.entry_index] = w.entry_value;
            else
                short_tab[w.entry_index] = w.entry_value;
        end else begin
            expected_readings.push_back(predict_reading(w.sensor_kind, w.sample));
        end
    endtask

    task automatic write_entry(input logic kind, input logic [3:0] idx, input logic [9:0] val);
        t_sensor_word w;
        w.req_type    = sti_pkg::REQ_WRITE;
        w.sensor_kind = kind;
        w.entry_index = idx;
        w.entry_value = val;
        w.sample      = 10'($urandom);
        send_word(w);
    endtask

    task automatic convert(input logic kind, input logic [9:0] smp);
        t_sensor_word w;
        w.req_type    = sti_pkg::REQ_CONVERT;
        w.sensor_kind = kind;
        w.entry_index = 4'($urandom);
        w.entry_value = 10'($urandom);
        w.sample      = smp;
        send_word(w);
    endtask

    task automatic load_table(input logic kind, input bit noisy);
        int level, drop;
        level = 1023 - int'($urandom_range(0, 120));
        for (int i = 0; i < SHORT_DEPTH; i++) begin
            write_entry(kind, 4'(i), 10'(level));
            drop = int'($urandom_range(0, 80));
            if (noisy)
                level = int'($urandom_range(0, 1023));
            else
                level = (level > drop) ? level - drop : 0;
        end
    endtask

    task automatic apply_config();
        for (int r = 0; r < REG_COUNT; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= 3'(r);
            i_cfg_data  <= next_cfg[r];
            do @(posedge i_clk); while (!o_cfg_ready);
            cfg_regs[r] = next_cfg[r];
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [9:0] pick_sample(logic kind);
        int lo_s, hi_s;
        if (kind == sti_pkg::KIND_LONG) begin
            lo_s = int'(cfg_regs[sti_pkg::REG_LONG_MIN]);
            hi_s = int'(cfg_regs[sti_pkg::REG_LONG_MAX]);
        end else begin
            lo_s = int'(cfg_regs[sti_pkg::REG_SHORT_MIN]);
            hi_s = int'(cfg_regs[sti_pkg::REG_SHORT_MAX]);
        end
        case ($urandom_range(0, 3))
            0, 1: begin
                if (lo_s <= hi_s)
                    return 10'($urandom_range(hi_s, lo_s));
                return 10'($urandom);
            end
            2: return 10'(table_entry(kind, int'($urandom_range(0, 15)))
                          + int'($urandom_range(0, 2)) - 1);
            default: return 10'($urandom);
        endcase
    endfunction

    task automatic test_reset_defaults();
        load_table(sti_pkg::KIND_SHORT, 1'b0);
        load_table(sti_pkg::KIND_LONG, 1'b0);
        convert(sti_pkg::KIND_SHORT, 10'd0);
        convert(sti_pkg::KIND_SHORT, 10'd1023);
        convert(sti_pkg::KIND_LONG, 10'd0);
        convert(sti_pkg::KIND_LONG, 10'd1023);
        convert(sti_pkg::KIND_SHORT, short_tab[7]);
        convert(sti_pkg::KIND_LONG, long_tab[15]);
        wait_quiet();
    endtask

    task automatic test_clamp_order();
        next_cfg[sti_pkg::REG_SHORT_MAX] = 10'd600;
        next_cfg[sti_pkg::REG_SHORT_MIN] = 10'd200;
        next_cfg[sti_pkg::REG_LONG_MAX]  = 10'd0;
        next_cfg[sti_pkg::REG_LONG_MIN]  = 10'd1023;
        apply_config();
        convert(sti_pkg::KIND_SHORT, 10'd601);
        convert(sti_pkg::KIND_SHORT, 10'd600);
        convert(sti_pkg::KIND_SHORT, 10'd200);
        convert(sti_pkg::KIND_SHORT, 10'd199);
        // max below min: the near clamp wins
        convert(sti_pkg::KIND_LONG, 10'd0);
        convert(sti_pkg::KIND_LONG, 10'd1);
        convert(sti_pkg::KIND_LONG, 10'd1023);
        wait_quiet();
    endtask

    task automatic test_segment_edges();
        next_cfg[sti_pkg::REG_SHORT_MAX]  = 10'd1023;
        next_cfg[sti_pkg::REG_SHORT_MIN]  = 10'd0;
        next_cfg[sti_pkg::REG_LONG_MAX]   = 10'd1023;
        next_cfg[sti_pkg::REG_LONG_MIN]   = 10'd0;
        next_cfg[sti_pkg::REG_SHORT_LAST] = 10'd0;
        next_cfg[sti_pkg::REG_LONG_LAST]  = 10'd15;
        next_cfg[sti_pkg::REG_SHORT_STEP] = 10'd15;
        next_cfg[sti_pkg::REG_LONG_STEP]  = 10'd15;
        apply_config();
        write_entry(sti_pkg::KIND_SHORT, 4'd0, 10'd500);
        write_entry(sti_pkg::KIND_SHORT, 4'd1, 10'd500);
        convert(sti_pkg::KIND_SHORT, 10'd700);
        convert(sti_pkg::KIND_SHORT, 10'd100);
        write_entry(sti_pkg::KIND_SHORT, 4'd1, 10'd493);
        convert(sti_pkg::KIND_SHORT, 10'd501);
        convert(sti_pkg::KIND_SHORT, 10'd1023);
        write_entry(sti_pkg::KIND_LONG, 4'd14, 10'd310);
        write_entry(sti_pkg::KIND_LONG, 4'd15, 10'd300);
        convert(sti_pkg::KIND_LONG, 10'd0);
        wait_quiet();
    endtask

    task automatic test_random_traffic();
        logic       kind;
        logic [3:0] idx;
        int         hi_n, lo_n;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            steady = (phase % 4 == 3);
            for (int r = 0; r < REG_COUNT; r++) begin
                case (3'(r))
                    sti_pkg::REG_SHORT_MAX, sti_pkg::REG_LONG_MAX: begin
                        if (phase == 0)
                            next_cfg[r] = 10'd0;
                        else if (phase == 1 || $urandom_range(0, 3) == 0)
                            next_cfg[r] = 10'd1023;
                        else if ($urandom_range(0, 7) == 0)
                            next_cfg[r] = 10'($urandom);
                        else
                            next_cfg[r] = 10'($urandom_range(512, 1023));
                    end
                    sti_pkg::REG_SHORT_MIN, sti_pkg::REG_LONG_MIN: begin
                        if (phase == 0 || $urandom_range(0, 3) == 0)
                            next_cfg[r] = 10'd0;
                        else if (phase == 1)
                            next_cfg[r] = 10'd1023;
                        else if ($urandom_range(0, 7) == 0)
                            next_cfg[r] = 10'($urandom);
                        else
                            next_cfg[r] = 10'($urandom_range(0, 400));
                    end
                    sti_pkg::REG_SHORT_LAST, sti_pkg::REG_LONG_LAST: begin
                        if (phase == 0)
                            next_cfg[r] = 10'd1;
                        else if (phase == 1)
                            next_cfg[r] = 10'd15;
                        else
                            next_cfg[r] = 10'($urandom_range(0, 15));
                    end
                    default: begin
                        if (phase == 0)
                            next_cfg[r] = 10'd1;
                        else if (phase == 1)
                            next_cfg[r] = 10'd15;
                        else if ($urandom_range(0, 9) == 0)
                            next_cfg[r] = 10'd0;
                        else
                            next_cfg[r] = 10'($urandom_range(1, 15));
                    end
                endcase
            end
            apply_config();
            if ($urandom_range(0, 1) == 1)
                load_table(sti_pkg::KIND_SHORT, phase == 5);
            if ($urandom_range(0, 1) == 1)
                load_table(sti_pkg::KIND_LONG, phase == 6);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                kind = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 6) == 0) begin
                    idx  = 4'($urandom);
                    hi_n = (idx > 4'd0) ? table_entry(kind, int'(idx) - 1) : 1023;
                    lo_n = (idx < 4'd15) ? table_entry(kind, int'(idx) + 1) : 0;
                    if ($urandom_range(0, 1) == 1)
                        write_entry(kind, idx, 10'($urandom));
                    else
                        write_entry(kind, idx, 10'($urandom_range(hi_n, lo_n)));
                end else begin
                    convert(kind, pick_sample(kind));
                end
            end
            wait_quiet();
        end
        steady = 1'b0;
    endtask

    initial begin : reading_checker
        int       stall;
        t_reading got, want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.distance_cm = m_axis_tdata;
            got.clamped     = m_axis_tuser;
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual distance_cm %0d clamped %0d",
                         $time, got.distance_cm, got.clamped);
                errors++;
            end else begin
                want = expected_readings.pop_front();
                if (got.distance_cm !== want.distance_cm) begin
                    $display("%0t: distance_cm expected %0d actual %0d",
                             $time, want.distance_cm, got.distance_cm);
                    errors++;
                end
                if (got.clamped !== want.clamped) begin
                    $display("%0t: clamped expected %0d actual %0d",
                             $time, want.clamped, got.clamped);
                    errors++;
                end
            end
        end
    end

    initial begin
        cfg_regs[sti_pkg::REG_SHORT_MAX]  = 10'd1023;
        cfg_regs[sti_pkg::REG_SHORT_MIN]  = 10'd0;
        cfg_regs[sti_pkg::REG_LONG_MAX]   = 10'd1023;
        cfg_regs[sti_pkg::REG_LONG_MIN]   = 10'd0;
        cfg_regs[sti_pkg::REG_SHORT_LAST] = 10'd15;
        cfg_regs[sti_pkg::REG_LONG_LAST]  = 10'd15;
        cfg_regs[sti_pkg::REG_SHORT_STEP] = 10'd1;
        cfg_regs[sti_pkg::REG_LONG_STEP]  = 10'd5;
        for (int r = 0; r < REG_COUNT; r++)
            next_cfg[r] = cfg_regs[r];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_clamp_order();
        test_segment_edges();
        test_random_traffic();
        wait_quiet();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("status: fail");
        $finish;
    end

endmodule
